[rtl/core/chm_pkg.sv]
package chm_pkg;

	// Default geometry of the map.
	localparam int BUCKETS_DEF = 'h65;
	localparam int ENTRIES_DEF = 256;

	// Operation codes carried in a request.
	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} chm_cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_WALK,
		ST_REM1,
		ST_REM2,
		ST_TAKE,
		ST_RESP
	} chm_state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key_id;
		logic [31:0] new_value;
	} chm_req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] stored_value;
		logic        pool_full;
	} chm_rsp_t;

endpackage

[rtl/core/chm_ram.sv]
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/chm_bucket_mod.sv]
module chm_bucket_mod import chm_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   key,
	output logic          done,
	output logic [BW-1:0] bucket
);

	logic [31:0]   key_q;
	logic [BW-1:0] r_q;
	logic [1:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [BW:0]   r;

	// Eight bits of the key per cycle, most significant first, each folded
	// into the remainder by a doubling and one conditional subtraction.
	always_comb begin
		r = {1'b0, r_q};
		for (int i = 0; i < 8; i++) begin
			r = {r[BW-1:0], key_q[31-i]};
			if (r >= (BW+1)'(BUCKETS)) begin
				r = r - (BW+1)'(BUCKETS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			r_q   <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[23:0], 8'd0};
			r_q   <= r[BW-1:0];
		end
	end

	assign done   = done_q;
	assign bucket = r_q;

endmodule

[rtl/core/chained_id_hash_map.sv]
// Chained hash map from 32-bit ids to 32-bit values, one request at a time.
// A request has its id reduced to a bucket (eight bits per cycle), then reads
// the bucket head, then walks the chain entry by entry through the entry
// memory and finally answers. A lookup or update stops at the matching entry
// and a miss at the end of the chain; an insert of a new id takes an entry
// from the free list if there is one, else a fresh one, and a remove of a
// present id then unlinks the entry and returns it to the free list. A clear
// goes straight to the answer state. The sequencer returns to idle before it
// takes the next request, and a stalled response holds it in the answer state.
// Clear drops every bucket at once through per-bucket valid flags, so no
// clearing pass is ever needed. An insert that finds no free entry answers
// pool_full.
module chained_id_hash_map import chm_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  chm_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output chm_rsp_t rsp
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NONE = LW'(ENTRIES);

	typedef struct packed {
		logic [31:0]   key;
		logic [31:0]   val;
		logic [LW-1:0] link;
	} entry_t;

	chm_state_t    state_q, state_d;
	chm_req_t      req_q, req_d;
	logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, head_q, head_d;
	logic [LW-1:0] steps_q, steps_d, free_q, free_d, fresh_q, fresh_d;
	entry_t        cur_ent_q, cur_ent_d, prev_ent_q, prev_ent_d;
	chm_rsp_t      res_q, res_d, rsp_q, rsp_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic [BUCKETS-1:0] bvalid_q, bvalid_d;

	logic          mod_start, mod_done;
	logic [BW-1:0] bkt;
	logic          ent_we, bh_we;
	logic [IW-1:0] ent_waddr, ent_raddr;
	entry_t        ent_wdata, ent_rdata;
	logic [LW-1:0] bh_wdata, bh_rdata, head_now, hv, push_slot;
	logic          miss, push;

	chm_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (req.key_id),
		.done   (mod_done),
		.bucket (bkt)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
		.clk   (clk),
		.we    (bh_we),
		.waddr (bkt),
		.wdata (bh_wdata),
		.raddr (bkt),
		.rdata (bh_rdata)
	);

	chm_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// The head of the addressed chain, an empty bucket reading as none.
	assign head_now = bvalid_q[bkt] ? bh_rdata : NONE;

	// Next state, memory accesses and the result of the request.
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		head_d      = head_q;
		steps_d     = steps_q;
		free_d      = free_q;
		fresh_d     = fresh_q;
		cur_ent_d   = cur_ent_q;
		prev_ent_d  = prev_ent_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		bvalid_d    = bvalid_q;
		req_ready   = (state_q == ST_IDLE);
		mod_start   = 1'b0;
		ent_we      = 1'b0;
		ent_waddr   = cur_q[IW-1:0];
		ent_wdata   = cur_ent_q;
		ent_raddr   = cur_q[IW-1:0];
		bh_we       = 1'b0;
		bh_wdata    = cur_ent_q.link;
		miss        = 1'b0;
		push        = 1'b0;
		push_slot   = cur_q;
		hv          = head_q;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_d = req;
					if (req.cmd == CMD_CLEAR) begin
						bvalid_d = '0;
						free_d   = NONE;
						fresh_d  = '0;
						res_d    = '0;
						state_d  = ST_RESP;
					end else begin
						mod_start = 1'b1;
						state_d   = ST_HASH;
					end
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				head_d  = head_now;
				hv      = head_now;
				prev_d  = NONE;
				steps_d = '0;
				if (head_now < NONE) begin
					cur_d     = head_now;
					ent_raddr = head_now[IW-1:0];
					state_d   = ST_WALK;
				end else begin
					miss = 1'b1;
				end
			end
			ST_WALK: begin
				if (ent_rdata.key == req_q.key_id) begin
					cur_ent_d = ent_rdata;
					res_d     = '{found: 1'b1, stored_value: 32'd0, pool_full: 1'b0};
					case (req_q.cmd)
						CMD_LOOKUP: begin
							res_d.stored_value = ent_rdata.val;
							state_d = ST_RESP;
						end
						CMD_INSERT: begin
							ent_we    = 1'b1;
							ent_wdata = '{key: ent_rdata.key, val: req_q.new_value,
								link: ent_rdata.link};
							state_d   = ST_RESP;
						end
						default: begin
							state_d = ST_REM1;
						end
					endcase
				end else if (ent_rdata.link < NONE && steps_q != LW'(ENTRIES - 1)) begin
					prev_d     = cur_q;
					prev_ent_d = ent_rdata;
					cur_d      = ent_rdata.link;
					steps_d    = steps_q + 1'b1;
					ent_raddr  = ent_rdata.link[IW-1:0];
				end else begin
					miss = 1'b1;
				end
			end
			ST_REM1: begin
				// Unlink: the predecessor or the bucket head skips the entry.
				if (prev_q < NONE) begin
					ent_we    = 1'b1;
					ent_waddr = prev_q[IW-1:0];
					ent_wdata = '{key: prev_ent_q.key, val: prev_ent_q.val,
						link: cur_ent_q.link};
				end else begin
					bh_we         = 1'b1;
					bh_wdata      = cur_ent_q.link;
					bvalid_d[bkt] = 1'b1;
				end
				state_d = ST_REM2;
			end
			ST_REM2: begin
				// The freed entry goes to the front of the free list.
				ent_we    = 1'b1;
				ent_wdata = '{key: cur_ent_q.key, val: cur_ent_q.val, link: free_q};
				free_d    = cur_q;
				state_d   = ST_RESP;
			end
			ST_TAKE: begin
				free_d = ent_rdata.link;
				push   = 1'b1;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d       = res_q;
					rsp_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A chain walk that ended without a match.
		if (miss) begin
			res_d   = '0;
			state_d = ST_RESP;
			if (req_q.cmd == CMD_INSERT) begin
				if (free_q < NONE) begin
					cur_d     = free_q;
					ent_raddr = free_q[IW-1:0];
					state_d   = ST_TAKE;
				end else if (fresh_q < NONE) begin
					push      = 1'b1;
					push_slot = fresh_q;
					fresh_d   = fresh_q + 1'b1;
				end else begin
					res_d.pool_full = 1'b1;
				end
			end
		end

		// A new entry is written and becomes the head of its bucket.
		if (push) begin
			ent_we        = 1'b1;
			ent_waddr     = push_slot[IW-1:0];
			ent_wdata     = '{key: req_q.key_id, val: req_q.new_value, link: hv};
			bh_we         = 1'b1;
			bh_wdata      = push_slot;
			bvalid_d[bkt] = 1'b1;
			res_d         = '0;
			state_d       = ST_RESP;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= NONE;
			fresh_q     <= '0;
			bvalid_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_q      <= free_d;
			fresh_q     <= fresh_d;
			bvalid_q    <= bvalid_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		req_q      <= req_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		head_q     <= head_d;
		steps_q    <= steps_d;
		cur_ent_q  <= cur_ent_d;
		prev_ent_q <= prev_ent_d;
		res_q      <= res_d;
		rsp_q      <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The bucket unit finishes only while the sequencer waits for it.
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_HASH)
		else $error("bucket result outside the hash state");

	// Entry writes stay inside the pool.
	a_ent_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> {1'b0, ent_waddr} < (IW+1)'(ENTRIES))
		else $error("entry write beyond the pool");

	// The fresh count never runs past the pool size.
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NONE)
		else $error("fresh count overflow");

	// An accepted request always leaves the idle state.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer idle");

endmodule

[bench/chm_checker.sv]
// Watches both channels of the hash map, keeps its own copy of the map and
// compares every response with the answer predicted for its request.
module chm_checker import chm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  chm_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  chm_rsp_t rsp,
	output int       fail_count,
	output int       pending
);

	localparam int NB = BUCKETS_DEF;
	localparam int NE = ENTRIES_DEF;
	localparam logic [8:0] NIL = 9'(NE);

	logic [8:0]  head_q [NB];
	logic [31:0] key_q [NE];
	logic [31:0] val_q [NE];
	logic [8:0]  link_q [NE];
	logic [8:0]  free_head;
	logic [8:0]  fresh;
	chm_rsp_t    answers [$];

	function automatic void map_empty();
		for (int b = 0; b < NB; b++) begin
			head_q[b] = NIL;
		end
		free_head = NIL;
		fresh = '0;
	endfunction

	// Apply one request to the shadow map and return the answer it deserves.
	function automatic chm_rsp_t map_apply(chm_req_t r);
		chm_rsp_t a;
		int b;
		logic [8:0] cur, prev, slot;
		a = '0;
		b = int'(r.key_id % 32'(NB));
		if (chm_cmd_t'(r.cmd) == CMD_CLEAR) begin
			map_empty();
			return a;
		end
		cur = head_q[b];
		prev = NIL;
		slot = NIL;
		for (int s = 0; s < NE && cur < NIL; s++) begin
			if (key_q[cur] == r.key_id) begin
				slot = cur;
				break;
			end
			prev = cur;
			cur = link_q[cur];
		end
		a.found = (slot != NIL);
		case (chm_cmd_t'(r.cmd))
			CMD_LOOKUP: begin
				if (a.found) a.stored_value = val_q[slot];
			end
			CMD_INSERT: begin
				if (a.found) begin
					val_q[slot] = r.new_value;
				end else begin
					if (free_head != NIL) begin
						slot = free_head;
						free_head = link_q[slot];
					end else if (fresh < NIL) begin
						slot = fresh;
						fresh = fresh + 1'b1;
					end
					if (slot != NIL) begin
						key_q[slot] = r.key_id;
						val_q[slot] = r.new_value;
						link_q[slot] = head_q[b];
						head_q[b] = slot;
					end else begin
						a.pool_full = 1'b1;
					end
				end
			end
			default: begin
				if (a.found) begin
					if (prev != NIL) link_q[prev] = link_q[slot];
					else head_q[b] = link_q[slot];
					link_q[slot] = free_head;
					free_head = slot;
				end
			end
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		map_empty();
	end

	assign pending = answers.size();

	// Requests update the shadow map; responses are compared with the oldest answer.
	always @(posedge clk) begin
		chm_rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				answers.push_back(map_apply(req));
			end
			if (rsp_valid && rsp_ready) begin
				if (answers.size() == 0) begin
					report_mismatch("unexpected response", 32'(rsp), '0);
				end else begin
					want = answers.pop_front();
					if (rsp.found !== want.found)
						report_mismatch("found", 32'(rsp.found), 32'(want.found));
					if (rsp.stored_value !== want.stored_value)
						report_mismatch("stored_value", rsp.stored_value, want.stored_value);
					if (rsp.pool_full !== want.pool_full)
						report_mismatch("pool_full", 32'(rsp.pool_full), 32'(want.pool_full));
				end
			end
		end
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	import chm_pkg::*;

	localparam int WATCHDOG = 20000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	chm_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	chm_rsp_t rsp;
	int       fail_count;
	int       pending;
	int       send_idle = 0;
	int       recv_stall = 0;
	int       quiet = 0;

	always #5 clk = ~clk;

	chained_id_hash_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	chm_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver stalls at random with the percentage of the current phase.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall);
	end

	// Watchdog on cycles in which neither channel moves a request or response.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Present one request and hold it until it is taken. Valid stays high
	// after acceptance; the next request or an idle cycle takes it down.
	task automatic send(chm_cmd_t c, logic [31:0] k, logic [31:0] v);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: c, key_id: k, new_value: v};
		do @(posedge clk); while (!req_ready);
	endtask

	// Ids from a small pool so that chains collide and hits are common.
	function automatic logic [31:0] pick_key(int pool);
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - 32'($urandom_range(3)) * 101;
			default: return 32'($urandom_range(pool)) * 101 + 32'($urandom_range(2));
		endcase
	endfunction

	task automatic random_phase(int n, int pool);
		int r;
		chm_cmd_t c;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(199);
			if (r < 70) c = CMD_LOOKUP;
			else if (r < 150) c = CMD_INSERT;
			else if (r < 199) c = CMD_REMOVE;
			else c = CMD_CLEAR;
			send(c, pick_key(pool), $urandom());
		end
	endtask

	// Stop sending and wait until every response has arrived.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every command, misses, overwrite, removal.
		send(CMD_LOOKUP, 32'h0, 32'h0);
		send(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send(CMD_INSERT, 32'd101, 32'h1234_5678);
		send(CMD_INSERT, 32'd202, 32'h0);
		send(CMD_LOOKUP, 32'h0, 32'h0);
		send(CMD_LOOKUP, 32'd101, 32'h0);
		send(CMD_INSERT, 32'd101, 32'hDEAD_BEEF);
		send(CMD_LOOKUP, 32'd101, 32'h0);
		send(CMD_REMOVE, 32'd101, 32'h0);
		send(CMD_LOOKUP, 32'd101, 32'h0);
		send(CMD_REMOVE, 32'd101, 32'h0);
		send(CMD_LOOKUP, 32'd202, 32'h0);
		send(CMD_REMOVE, 32'd202, 32'h0);
		send(CMD_INSERT, 32'd303, 32'h5555_5555);
		send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_LOOKUP, 32'h0, 32'h0);
		send(CMD_LOOKUP, 32'd303, 32'h0);

		// Fill the pool until inserts of new ids report it full, then probe it.
		for (int i = 0; i < 260; i++) send(CMD_INSERT, 32'(i) * 7, $urandom());
		send(CMD_INSERT, 32'h8000_0001, 32'h1);
		send(CMD_INSERT, 32'd14, 32'h2);
		send(CMD_REMOVE, 32'd21, 32'h0);
		send(CMD_INSERT, 32'h8000_0001, 32'h3);
		send(CMD_LOOKUP, 32'h8000_0001, 32'h0);
		// Hold off until every response has arrived.
		drain();
		send(CMD_CLEAR, 32'h0, 32'h0);

		// Random phases with each idling pattern.
		send_idle = 0;  recv_stall = 0;  random_phase(300, 60);
		send_idle = 54; recv_stall = 0;  random_phase(300, 60);
		send_idle = 0;  recv_stall = 54; random_phase(300, 300);
		send_idle = 17; recv_stall = 17; random_phase(300, 30);
		send_idle = 0;  recv_stall = 0;  random_phase(300, 120);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/chm_pkg.sv
rtl/core/chm_ram.sv
rtl/core/chm_bucket_mod.sv
rtl/core/chained_id_hash_map.sv
bench/chm_checker.sv
bench/tb_top.sv
